// ----- rtl/smtd_pkg.sv -----
// ----------------------------------------------------------------------------
// smtd_pkg
// Shared types and constants for the sparse multi-tap delay unit.
// ----------------------------------------------------------------------------
package smtd_pkg;

  // default sizes
  localparam int DEF_BUFFER_DEPTH = 4096;
  localparam int DEF_MAX_TAPS     = 64;
  localparam int DEF_SAMPLE_WIDTH = 24;

  // fixed field widths
  localparam int GAIN_W      = 16;
  localparam int TAP_INDEX_W = 6;
  localparam int TAP_DELAY_W = 12;
  localparam int ACTIVE_W    = 7;
  localparam int FRAC_BITS   = 15;

  // command codes carried in tuser
  localparam logic CMD_SAMPLE    = 1'b0;
  localparam logic CMD_TAP_WRITE = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAP_RED1,
    ST_TAP_RED2,
    ST_TAP_WRITE,
    ST_RUN,
    ST_DONE
  } smtd_state_t;

  // multiply-accumulate controls
  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } smtd_mac_ctrl_t;

endpackage

// ----- rtl/smtd_ram.sv -----
// ----------------------------------------------------------------------------
// smtd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module smtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/smtd_delay_mod.sv -----
// ----------------------------------------------------------------------------
// smtd_delay_mod
// Reduces a tap delay modulo the buffer depth: reciprocal multiply, back
// multiply, then one conditional subtract. Two register stages.
// ----------------------------------------------------------------------------
module smtd_delay_mod #(
  parameter int BUFFER_DEPTH = smtd_pkg::DEF_BUFFER_DEPTH,
  parameter int AW           = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic                             clk,
  input  logic [smtd_pkg::TAP_DELAY_W-1:0] delay,
  output logic [AW-1:0]                    delay_mod
);
  import smtd_pkg::*;

  localparam int SHIFT   = 24;
  localparam int RECIP_W = 25;
  localparam int RW      = 18;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / BUFFER_DEPTH);
  localparam logic [RW-1:0]      DEPTH_C = RW'(BUFFER_DEPTH);

  logic [TAP_DELAY_W+RECIP_W-1:0] prod_q;
  logic [TAP_DELAY_W-1:0]         quot;
  logic [TAP_DELAY_W-1:0]         delay_s1;
  logic [TAP_DELAY_W+RW-1:0]      prod_b;
  logic [TAP_DELAY_W-1:0]         rem;
  logic [RW-1:0]                  rem_ext;
  logic [RW-1:0]                  rem_fix;

  // stage 1: quotient estimate, never above the true quotient
  assign prod_q = TAP_DELAY_W'(delay) * RECIP;

  always_ff @(posedge clk) begin
    quot     <= prod_q[SHIFT +: TAP_DELAY_W];
    delay_s1 <= delay;
  end

  // stage 2: remainder estimate, below twice the depth
  assign prod_b = quot * DEPTH_C;

  always_ff @(posedge clk) begin
    rem <= delay_s1 - prod_b[TAP_DELAY_W-1:0];
  end

  // final correction
  assign rem_ext   = RW'(rem);
  assign rem_fix   = (rem_ext >= DEPTH_C) ? (rem_ext - DEPTH_C) : rem_ext;
  assign delay_mod = rem_fix[AW-1:0];

endmodule

// ----- rtl/smtd_mac.sv -----
// ----------------------------------------------------------------------------
// smtd_mac
// Gain times sample multiply, accumulate, then round from Q.15 and saturate.
// ----------------------------------------------------------------------------
module smtd_mac #(
  parameter int SAMPLE_WIDTH = smtd_pkg::DEF_SAMPLE_WIDTH,
  parameter int MAX_TAPS     = smtd_pkg::DEF_MAX_TAPS
) (
  input  logic                               clk,
  input  smtd_pkg::smtd_mac_ctrl_t           ctrl,
  input  logic signed [smtd_pkg::GAIN_W-1:0] gain,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample,
  output logic signed [SAMPLE_WIDTH-1:0]     result
);
  import smtd_pkg::*;

  localparam int TW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int PROD_W = SAMPLE_WIDTH + GAIN_W;
  localparam int ACC_W  = PROD_W + TW + 1;
  localparam int QW     = ACC_W - FRAC_BITS;
  localparam logic signed [QW-1:0] SAT_HI = {{(TW + 3){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [QW-1:0] SAT_LO = {{(TW + 3){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1 << (FRAC_BITS - 1));

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rounded;
  logic signed [QW-1:0]     quant;

  // product register
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= gain * sample;
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // round half up, floor shift, clamp
  assign rounded = acc + HALF;
  assign quant   = rounded[ACC_W-1:FRAC_BITS];

  always_comb begin
    if (quant > SAT_HI) begin
      result = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (quant < SAT_LO) begin
      result = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      result = quant[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

// ----- rtl/sparse_multi_tap_delay_unit.sv -----
// ----------------------------------------------------------------------------
// sparse_multi_tap_delay_unit
// Sparse multi-tap delay line (velvet-noise style FIR) for one audio channel.
// ----------------------------------------------------------------------------
// A sample request (tuser 0) produces one output sample: the sum over the
// first min(active_taps, MAX_TAPS) table entries of gain (Q1.15) times the
// stored sample delayed by that tap, rounded half up and saturated; the new
// sample is then stored. A tap request (tuser 1) with an index below MAX_TAPS
// loads one delay and gain and produces no output. Each tap of a sample takes
// one tap table read and one delay buffer read, through the single read port
// of each RAM, followed by the three-stage multiply-accumulate drain. After
// reset the unit clears every tap table entry before it takes requests
// (configuration writes are always taken). Unwritten delay buffer entries
// read as zero without a clearing pass. The output holds one finished
// result, so a new request is taken while that result waits.
// ----------------------------------------------------------------------------
module sparse_multi_tap_delay_unit #(
  parameter int BUFFER_DEPTH = smtd_pkg::DEF_BUFFER_DEPTH,
  parameter int MAX_TAPS     = smtd_pkg::DEF_MAX_TAPS,
  parameter int SAMPLE_WIDTH = smtd_pkg::DEF_SAMPLE_WIDTH,
  parameter int IN_TDATA_W   = ((SAMPLE_WIDTH + smtd_pkg::TAP_INDEX_W +
                                 smtd_pkg::TAP_DELAY_W + smtd_pkg::GAIN_W + 7) / 8) * 8,
  parameter int OUT_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration: active_taps
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [smtd_pkg::ACTIVE_W-1:0]     cfg_data,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sample_in, tap_index, tap_delay, tap_gain
  input  logic [IN_TDATA_W-1:0]             s_axis_tdata,
  // cmd
  input  logic                              s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // sample_out
  output logic [OUT_TDATA_W-1:0]            m_axis_tdata
);
  import smtd_pkg::*;

  localparam int AW     = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int TAW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W  = ($clog2(MAX_TAPS + 1) > ACTIVE_W) ? $clog2(MAX_TAPS + 1) : ACTIVE_W;
  localparam int TAP_WW = AW + GAIN_W;
  localparam int F_IDX  = SAMPLE_WIDTH;
  localparam int F_DLY  = F_IDX + TAP_INDEX_W;
  localparam int F_GAIN = F_DLY + TAP_DELAY_W;

  // state and control
  smtd_state_t            state, state_next;
  logic [ACTIVE_W-1:0]    active_taps;
  logic [CNT_W-1:0]       n_eff;
  logic [CNT_W-1:0]       cnt;
  logic [TAW-1:0]         clr_cnt;
  logic [AW-1:0]          wr_ptr;
  logic                   filled;
  logic                   s1_v, s2_v, s3_v;
  logic                   issue;
  logic                   accept;
  logic                   out_load;
  logic                   tap_we;
  smtd_mac_ctrl_t         mac_ctrl;

  // captured request fields
  logic signed [SAMPLE_WIDTH-1:0] sample_reg;
  logic [TAP_INDEX_W-1:0]         idx_reg;
  logic [TAP_DELAY_W-1:0]         delay_reg;
  logic signed [GAIN_W-1:0]       gain_reg;

  // datapath
  logic [AW-1:0]                  delay_red;
  logic [TAW-1:0]                 tap_waddr;
  logic [TAP_WW-1:0]              tap_wdata;
  logic [TAP_WW-1:0]              tap_rdata;
  logic [AW-1:0]                  tap_delay_rd;
  logic [AW:0]                    rd_diff;
  logic [AW:0]                    rd_wrap;
  logic [AW-1:0]                  rd_addr;
  logic signed [GAIN_W-1:0]       s2_gain;
  logic                           s2_live;
  logic [SAMPLE_WIDTH-1:0]        dly_rdata;
  logic signed [SAMPLE_WIDTH-1:0] mac_sample;
  logic signed [SAMPLE_WIDTH-1:0] mac_result;
  logic [SAMPLE_WIDTH-1:0]        out_sample;
  logic                           idx_ok;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign idx_ok    = (32'(s_axis_tdata[F_IDX +: TAP_INDEX_W]) < MAX_TAPS);
  assign n_eff     = (32'(active_taps) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(active_taps);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_taps <= '0;
    end else if (cfg_valid && cfg_ready) begin
      active_taps <= cfg_data;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and controls
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    tap_we        = 1'b0;
    out_load      = 1'b0;
    mac_ctrl      = '0;
    unique case (state)
      ST_CLEAR: begin
        tap_we = 1'b1;
        if (clr_cnt == TAW'(MAX_TAPS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        mac_ctrl.clear = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser == CMD_SAMPLE) begin
            state_next = ST_RUN;
          end else if (idx_ok) begin
            state_next = ST_TAP_RED1;
          end
        end
      end
      ST_TAP_RED1: begin
        state_next = ST_TAP_RED2;
      end
      ST_TAP_RED2: begin
        state_next = ST_TAP_WRITE;
      end
      ST_TAP_WRITE: begin
        tap_we     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RUN: begin
        issue           = (cnt < n_eff);
        mac_ctrl.mul_en = s2_v;
        mac_ctrl.acc_en = s3_v;
        if (!issue && !s1_v && !s2_v && !s3_v) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // clear sweep and tap issue counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      cnt     <= '0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (accept) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // tap pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_reg <= s_axis_tdata[SAMPLE_WIDTH-1:0];
      idx_reg    <= s_axis_tdata[F_IDX +: TAP_INDEX_W];
      delay_reg  <= s_axis_tdata[F_DLY +: TAP_DELAY_W];
      gain_reg   <= s_axis_tdata[F_GAIN +: GAIN_W];
    end
  end

  // tap delay reduction
  smtd_delay_mod #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW)
  ) u_delay_mod (
    .clk       (clk),
    .delay     (delay_reg),
    .delay_mod (delay_red)
  );

  // tap table: cleared after reset, loaded by tap requests
  assign tap_waddr = (state == ST_CLEAR) ? clr_cnt : TAW'(idx_reg);
  assign tap_wdata = (state == ST_CLEAR) ? '0 : {gain_reg, delay_red};

  smtd_ram #(
    .WIDTH (TAP_WW),
    .DEPTH (MAX_TAPS),
    .AW    (TAW)
  ) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (tap_wdata),
    .raddr (cnt[TAW-1:0]),
    .rdata (tap_rdata)
  );

  // delay buffer read address, wrapped behind the write pointer
  assign tap_delay_rd = tap_rdata[AW-1:0];
  assign rd_diff      = {1'b0, wr_ptr} - {1'b0, tap_delay_rd};
  assign rd_wrap      = rd_diff + (AW + 1)'(BUFFER_DEPTH);
  assign rd_addr      = rd_diff[AW] ? rd_wrap[AW-1:0] : rd_diff[AW-1:0];

  // gain and written-entry flag follow the buffer read
  always_ff @(posedge clk) begin
    s2_gain <= tap_rdata[AW +: GAIN_W];
    s2_live <= filled || (rd_addr < wr_ptr);
  end

  smtd_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_delay_ram (
    .clk   (clk),
    .we    (out_load),
    .waddr (wr_ptr),
    .wdata (sample_reg),
    .raddr (rd_addr),
    .rdata (dly_rdata)
  );

  // never-written entries read as zero
  assign mac_sample = s2_live ? dly_rdata : '0;

  smtd_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_TAPS     (MAX_TAPS)
  ) u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .gain   (s2_gain),
    .sample (mac_sample),
    .result (mac_result)
  );

  // write pointer and fill flag
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      filled <= 1'b0;
    end else if (out_load) begin
      if (wr_ptr == AW'(BUFFER_DEPTH - 1)) begin
        wr_ptr <= '0;
        filled <= 1'b1;
      end else begin
        wr_ptr <= wr_ptr + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= mac_result;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'(out_sample);

endmodule
